[rtl/core/igbc_pkg.sv]
// ----------------------------------------------------------------------------
// IMU gyro bias calibration package
// Shared types and scale constants for the calibration and scaling block.
// ----------------------------------------------------------------------------
`default_nettype none

package igbc_pkg;

  localparam int unsigned GYRO_K  = 4588;
  localparam int unsigned ACC_G_K = 8187;
  localparam int unsigned G_MS2_K = 40167;

  localparam int unsigned SUM_W  = 28;
  localparam int unsigned OFF_W  = 24;
  localparam int unsigned SEEN_W = 17;

  // Register indexes of the configuration port.
  localparam logic CFG_CAL_SAMPLES    = 1'b0;
  localparam logic CFG_SETTLE_DISCARD = 1'b1;

  // One accepted sample as it travels from the front to the back part.
  typedef struct packed {
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [23:0]        t;
  } sample_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAL,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } be_state_t;

endpackage : igbc_pkg

`default_nettype wire

[rtl/core/igbc_front.sv]
// ----------------------------------------------------------------------------
// Front queue
// Accepts samples into a two-word queue that decouples input from processing.
// ----------------------------------------------------------------------------
`default_nettype none

module igbc_front
  import igbc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire sample_t push_data,
  output logic         full,
  output logic         q_valid,
  output sample_t      q_data,
  input  wire logic    q_take
);

  sample_t    mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = mem_r[rp_r];
  assign do_push = push && !full;

  // Pointer and count update.
  always_comb begin
    wp_nxt  = wp_r ^ do_push;
    rp_nxt  = rp_r ^ (q_take && q_valid);
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, q_take && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage words.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule : igbc_front

`default_nettype wire

[rtl/core/igbc_div.sv]
// ----------------------------------------------------------------------------
// Serial divider
// Restoring signed division of sum by sample count to Q8, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module igbc_div
  import igbc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [SUM_W-1:0] sum,
  input  wire logic [12:0]             divisor,
  output logic                         done,
  output logic signed [OFF_W-1:0]      quot
);

  localparam int unsigned NW = SUM_W + 8;

  logic [NW-1:0] num_r;
  logic [NW-1:0] q_r;
  logic [13:0]   rem_r;
  logic [12:0]   den_r;
  logic          neg_r;
  logic [5:0]    cnt_r;
  logic          busy_r;
  logic [13:0]   trial;
  logic signed [NW:0] res;

  assign trial = {rem_r[12:0], num_r[NW-1]};
  assign res   = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  // Quotient clamped to the offset range.
  always_comb begin
    if (res > $signed((NW+1)'(8388607))) begin
      quot = 24'sh7FFFFF;
    end else if (res < -$signed((NW+1)'(8388608))) begin
      quot = -24'sh800000;
    end else begin
      quot = res[OFF_W-1:0];
    end
  end

  assign done = busy_r && (cnt_r == 6'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'(NW);
    end else if (busy_r && cnt_r != 6'd0) begin
      cnt_r <= cnt_r - 6'd1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // One shift-subtract step per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= sum[SUM_W-1] ? NW'(-($signed({{8{sum[SUM_W-1]}}, sum}) <<< 8))
                            : NW'({{8{1'b0}}, sum} << 8);
      neg_r <= sum[SUM_W-1];
      rem_r <= 14'd0;
      q_r   <= '0;
      den_r <= divisor;
    end else if (busy_r && cnt_r != 6'd0) begin
      num_r <= {num_r[NW-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_r <= trial - {1'b0, den_r};
        q_r   <= {q_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[NW-2:0], 1'b0};
      end
    end
  end

endmodule : igbc_div

`default_nettype wire

[rtl/core/igbc_back.sv]
// ----------------------------------------------------------------------------
// Back end
// Sums during calibration, computes offsets, then scales each sample with a
// shared multiplier and holds the result word for the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module igbc_back
  import igbc_pkg::*;
#(
  parameter int unsigned MAX_CAL_COUNT = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [12:0] cal_samples,
  input  wire logic [7:0]  settle_discard,
  input  wire logic        q_valid,
  input  wire sample_t     q_data,
  output logic             q_take,
  output logic             out_valid,
  input  wire logic        out_take,
  output logic signed [21:0] rate_x, rate_y, rate_z,
  output logic signed [21:0] g_x, g_y, g_z,
  output logic signed [20:0] ms_x, ms_y, ms_z,
  output logic [23:0]        dt
);

  be_state_t st_r, st_nxt;
  sample_t   s_r;
  logic      cal_r;
  logic [SEEN_W-1:0] seen_r;
  logic signed [SUM_W-1:0] sum_r [3];
  logic signed [OFF_W-1:0] off_r [3];
  logic [1:0]  ax_r;
  logic [3:0]  step_r;
  logic [23:0] last_r;
  logic        have_r;
  logic signed [21:0] rate_r [3];
  logic signed [21:0] g_r [3];
  logic signed [20:0] ms_r [3];
  logic [23:0] dt_r;
  logic        ov_r;
  logic        div_go_r;

  // Saturating add of one gyro word into a 28-bit sum.
  function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] a, input logic signed [15:0] b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + (SUM_W+1)'(b);
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

  // Effective calibration count.
  logic [16:0] n_eff;
  always_comb begin
    if (cal_samples == 13'd0) begin
      n_eff = 17'd1;
    end else if ({4'd0, cal_samples} > 17'(MAX_CAL_COUNT)) begin
      n_eff = 17'(MAX_CAL_COUNT);
    end else begin
      n_eff = {4'd0, cal_samples};
    end
  end

  logic [SEEN_W-1:0] seen_inc;
  logic in_win, cal_end;
  assign in_win   = (seen_r >= 17'(settle_discard)) &&
                    (seen_r - 17'(settle_discard) < n_eff);
  assign seen_inc = (seen_r < 17'h1FFFF) ? seen_r + 17'd1 : seen_r;
  assign cal_end  = ({1'b0, seen_inc} >= 18'(settle_discard) + {1'b0, n_eff});

  // Divider, shared over the three axes. It starts in the cycle after the last
  // sum update or axis step, so it always latches the settled sum of ax_r.
  logic div_start, div_done;
  logic signed [OFF_W-1:0] div_q;
  igbc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .sum(sum_r[ax_r]),
    .divisor(n_eff[12:0]), .done(div_done), .quot(div_q)
  );

  // Shared multiplier: 26 x 17 signed, registered product.
  logic signed [25:0] ma;
  logic signed [16:0] mb;
  logic signed [42:0] prod_r;
  always_comb begin
    ma = '0;
    mb = '0;
    case (step_r)
      4'd0: begin
        ma = 26'($signed({s_r.gx, 8'd0})) - 26'(off_r[0]);
        mb = 17'(GYRO_K);
      end
      4'd1: begin
        ma = 26'($signed({s_r.gy, 8'd0})) - 26'(off_r[1]);
        mb = 17'(GYRO_K);
      end
      4'd2: begin
        ma = 26'($signed({s_r.gz, 8'd0})) - 26'(off_r[2]);
        mb = 17'(GYRO_K);
      end
      4'd3: begin ma = 26'(s_r.ax); mb = 17'(ACC_G_K); end
      4'd4: begin ma = 26'(s_r.ay); mb = 17'(ACC_G_K); end
      4'd5: begin ma = 26'(s_r.az); mb = 17'(ACC_G_K); end
      4'd6: begin ma = 26'(g_r[0]); mb = 17'(G_MS2_K); end
      4'd7: begin ma = 26'(g_r[1]); mb = 17'(G_MS2_K); end
      4'd8: begin ma = 26'(g_r[2]); mb = 17'(G_MS2_K); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  logic [3:0] pstep_r;
  always_ff @(posedge clk) begin
    prod_r  <= ma * mb;
    pstep_r <= step_r;
  end

  // Next state. A scaling sample is only taken once the output word is free.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_valid && (cal_r || !ov_r)) st_nxt = cal_r ? ST_CAL : ST_MUL;
      ST_CAL:  if (cal_end) st_nxt = ST_DIV; else st_nxt = ST_IDLE;
      ST_DIV:  if (div_done && ax_r == 2'd2) st_nxt = ST_IDLE;
      ST_MUL:  if (step_r == 4'd9) st_nxt = ST_OUT;
      ST_OUT:  if (!ov_r) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_take    = (st_r == ST_IDLE) && q_valid && (cal_r || !ov_r);
    div_start = div_go_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      cal_r    <= 1'b1;
      seen_r   <= '0;
      have_r   <= 1'b0;
      last_r   <= '0;
      ov_r     <= 1'b0;
      ax_r     <= 2'd0;
      step_r   <= 4'd0;
      div_go_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= '0;
        off_r[i] <= '0;
      end
    end else begin
      st_r     <= st_nxt;
      div_go_r <= ((st_r == ST_CAL) && cal_end) ||
                  ((st_r == ST_DIV) && div_done && ax_r != 2'd2);
      if (out_take) ov_r <= 1'b0;
      if (q_take) begin
        s_r    <= q_data;
        step_r <= 4'd0;
      end
      case (st_r)
        ST_CAL: begin
          if (in_win) begin
            sum_r[0] <= sat_add(sum_r[0], s_r.gx);
            sum_r[1] <= sat_add(sum_r[1], s_r.gy);
            sum_r[2] <= sat_add(sum_r[2], s_r.gz);
          end
          seen_r <= seen_inc;
          ax_r   <= 2'd0;
        end
        ST_DIV: begin
          if (div_done) begin
            off_r[ax_r] <= div_q;
            if (ax_r == 2'd2) cal_r <= 1'b0;
            else ax_r <= ax_r + 2'd1;
          end
        end
        ST_MUL: begin
          step_r <= step_r + 4'd1;
          if (step_r != 4'd0) begin
            case (pstep_r)
              4'd0, 4'd1, 4'd2:
                rate_r[pstep_r[1:0]] <= prod_r[37:16];
              4'd3, 4'd4, 4'd5:
                g_r[2'(pstep_r - 4'd3)] <= prod_r[29:8];
              4'd6, 4'd7, 4'd8:
                ms_r[2'(pstep_r - 4'd6)] <= prod_r[36:16];
              default: ;
            endcase
          end
        end
        ST_OUT: begin
          if (!ov_r) begin
            ov_r   <= 1'b1;
            dt_r   <= have_r ? s_r.t - last_r : 24'd0;
            last_r <= s_r.t;
            have_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign rate_x = rate_r[0];
  assign rate_y = rate_r[1];
  assign rate_z = rate_r[2];
  assign g_x = g_r[0];
  assign g_y = g_r[1];
  assign g_z = g_r[2];
  assign ms_x = ms_r[0];
  assign ms_y = ms_r[1];
  assign ms_z = ms_r[2];
  assign dt = dt_r;

endmodule : igbc_back

`default_nettype wire

[rtl/core/imu_gyro_bias_cal_and_scaling.sv]
// The shared multiplier runs nine products for each scaled sample, and the back
// end holds one sample at a time; a new sample waits while the previous word
// is unread. After the last calibration sample the serial divider produces
// the three offsets, one axis after another.
// Reset: rst_n synchronous, active low; calibration restarts after reset.
// ----------------------------------------------------------------------------
// IMU gyro bias calibration and scaling
// Front queue, back end with divider and shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_gyro_bias_cal_and_scaling
  import igbc_pkg::*;
#(
  parameter int unsigned MAX_CAL_COUNT = 4096
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  output logic      full,
  input  wire logic signed [15:0] in_gyro_x_raw,
  input  wire logic signed [15:0] in_gyro_y_raw,
  input  wire logic signed [15:0] in_gyro_z_raw,
  input  wire logic signed [15:0] in_accel_x_raw,
  input  wire logic signed [15:0] in_accel_y_raw,
  input  wire logic signed [15:0] in_accel_z_raw,
  input  wire logic [23:0]        in_sensor_time,
  output logic      empty,
  input  wire logic pop,
  output logic signed [21:0] out_rate_x_dps,
  output logic signed [21:0] out_rate_y_dps,
  output logic signed [21:0] out_rate_z_dps,
  output logic signed [21:0] out_accel_x_g,
  output logic signed [21:0] out_accel_y_g,
  output logic signed [21:0] out_accel_z_g,
  output logic signed [20:0] out_accel_x_ms2,
  output logic signed [20:0] out_accel_y_ms2,
  output logic signed [20:0] out_accel_z_ms2,
  output logic [23:0]        out_tick_delta,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic          cfg_index,
  input  wire logic [12:0]   cfg_data
);

  logic [12:0] cal_r;
  logic [7:0]  settle_r;
  sample_t     in_s, q_s;
  logic        q_valid, q_take, ov;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r    <= 13'd512;
      settle_r <= 8'd50;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CAL_SAMPLES:    cal_r    <= cfg_data;
        CFG_SETTLE_DISCARD: settle_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_s = '{gx: in_gyro_x_raw, gy: in_gyro_y_raw, gz: in_gyro_z_raw,
                  ax: in_accel_x_raw, ay: in_accel_y_raw, az: in_accel_z_raw,
                  t: in_sensor_time};

  igbc_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(in_s), .full(full),
    .q_valid(q_valid), .q_data(q_s), .q_take(q_take)
  );

  igbc_back #(.MAX_CAL_COUNT(MAX_CAL_COUNT)) u_back (
    .clk(clk), .rst_n(rst_n), .cal_samples(cal_r), .settle_discard(settle_r),
    .q_valid(q_valid), .q_data(q_s), .q_take(q_take),
    .out_valid(ov), .out_take(pop && ov),
    .rate_x(out_rate_x_dps), .rate_y(out_rate_y_dps), .rate_z(out_rate_z_dps),
    .g_x(out_accel_x_g), .g_y(out_accel_y_g), .g_z(out_accel_z_g),
    .ms_x(out_accel_x_ms2), .ms_y(out_accel_y_ms2), .ms_z(out_accel_z_ms2),
    .dt(out_tick_delta)
  );

  assign empty = !ov;

endmodule : imu_gyro_bias_cal_and_scaling

`default_nettype wire

[rtl/core/igbc_checker.sv]
// ----------------------------------------------------------------------------
// Port checker
// Watches the queue-style ports of the calibration block.
// ----------------------------------------------------------------------------
`default_nettype none

module igbc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic full,
  input wire logic empty,
  input wire logic pop,
  input wire logic [23:0] out_tick_delta
);

  // Out of reset the block holds no result.
  a_empty_rst: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result present after reset");

  // Out of reset the input queue has room.
  a_full_rst: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input full after reset");

  // A waiting word that is not taken stays.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
    else $error("result dropped");

  // The word held does not change while it waits.
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> $stable(out_tick_delta))
    else $error("result changed while waiting");

endmodule : igbc_checker

bind imu_gyro_bias_cal_and_scaling igbc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .full(full), .empty(empty), .pop(pop),
  .out_tick_delta(out_tick_delta)
);

`default_nettype wire
